>>> hdl/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// Shared constants and operation codes for the rational arithmetic unit.
// ---------------------------------------------------------------------------
package rau_pkg;
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int KIND_W = 4;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_REDUCE = 4'd4, OP_IS_RED = 4'd5, OP_COMMON = 4'd6, OP_SIGN = 4'd7,
    OP_CMP = 4'd8
  } op_t;
endpackage

>>> hdl/rau_divider.sv
// ---------------------------------------------------------------------------
// rau_divider
// Restoring divider, one quotient bit per cycle; used for gcd steps and for
// the final division of numerator and denominator by the gcd.
// ---------------------------------------------------------------------------
module rau_divider #(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt;
  logic busy;
  logic [W-1:0] q, d;
  logic [W:0] r;
  logic [W:0] trial;

  assign trial = {r[W-1:0], q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        q    <= dividend;
        d    <= divisor;
        r    <= '0;
      end else if (busy) begin
        if (trial[W]) begin
          r <= {r[W-1:0], q[W-1]};
          q <= {q[W-2:0], 1'b0};
        end else begin
          r <= trial;
          q <= {q[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign rem  = r[W-1:0];
endmodule

>>> hdl/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, sub, mul, div, reduce, lowest-terms test, common denominator,
// sign and compare on two signed fractions.
// ---------------------------------------------------------------------------
// channel   signals                                   direction
// command   start, busy, kind, num_a..den_b            in (busy out)
// result    done, res_num, res_den, second_num,        out
//           second_den, verdict, error
//
// Arithmetic and reduce items are timed by the single shared bit-serial
// divider (gcd remainder steps, then one division each for numerator and
// denominator); the lowest-terms test skips the two final divisions. Common
// denominator, sign and compare do not use the divider, and a rejected item
// goes straight to the output state. rst clears the sequencer.
// The result strobe lasts one cycle; the receiver cannot stall.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [rau_pkg::KIND_W-1:0]          kind,
  input  logic signed [15:0]                 num_a,
  input  logic signed [15:0]                 den_a,
  input  logic signed [15:0]                 num_b,
  input  logic signed [15:0]                 den_b,
  output logic                               done,
  output logic signed [rau_pkg::NUM_W-1:0]   res_num,
  output logic signed [rau_pkg::DEN_W-1:0]   res_den,
  output logic signed [rau_pkg::NUM_W-1:0]   second_num,
  output logic signed [rau_pkg::DEN_W-1:0]   second_den,
  output logic signed [1:0]                  verdict,
  output logic                               error
);
  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;      // product width
  localparam int MW = PW + 2;      // magnitude width incl. add carry
  localparam int FW = MW;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_OUT
  } state_t;
  state_t state;

  logic [KIND_W-1:0] k;
  logic signed [OW-1:0] an, ad, bn, bd;
  logic signed [PW-1:0] p1, p2, p3;   // an*bd or an*bn, bn*ad, ad*bd or ad*bn
  logic neg_n, neg_d;
  logic [MW-1:0] nmag, dmag, gb;
  logic signed [OW-1:0] sa, sb; // shared multiplier operands
  logic signed [PW-1:0] prod;
  logic [1:0] mstep;
  logic dgo, ddone;
  logic [FW-1:0] dq, dr, dnd, dvs;
  logic [FW-1:0] qn;

  logic signed [OW-1:0] xa, xad, xb, xbd;
  assign xa  = OW'(num_a);
  assign xad = OW'(den_a);
  assign xb  = OW'(num_b);
  assign xbd = OW'(den_b);

  assign prod = PW'(sa) * PW'(sb);

  rau_divider #(.W(FW)) u_div (
    .clk(clk), .rst(rst), .go(dgo), .dividend(dnd), .divisor(dvs),
    .done(ddone), .quot(dq), .rem(dr)
  );

  function automatic logic [MW-1:0] mag(input logic signed [PW-1:0] v);
    logic signed [MW-1:0] e;
    e = MW'(v);
    return (v < 0) ? MW'(-e) : MW'(e);
  endfunction

  logic [MW-1:0] pm, qm;
  logic pn, qneg;
  always_comb begin
    pm = mag(p1);
    qm = mag(p2);
    pn = p1 < 0;
    qneg = (p2 < 0) != (k == KIND_W'(OP_SUB));
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      dgo   <= 1'b0;
    end else begin
      done <= 1'b0;
      dgo  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            k <= kind; an <= xa; ad <= xad; bn <= xb; bd <= xbd;
            res_num <= '0; res_den <= '0; second_num <= '0; second_den <= '0;
            verdict <= '0; error <= 1'b0;
            mstep <= '0;
            if (kind > KIND_W'(OP_CMP) || xad == 0 ||
                (!(kind == KIND_W'(OP_REDUCE) || kind == KIND_W'(OP_IS_RED) ||
                   kind == KIND_W'(OP_SIGN)) && xbd == 0) ||
                (kind == KIND_W'(OP_DIV) && xb == 0)) begin
              error <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_MUL;
            end
            // first multiply operands
            sa <= xa;
            sb <= (kind == KIND_W'(OP_MUL)) ? xb : xbd;
          end
        end
        // three products through the one multiplier
        S_MUL: begin
          mstep <= mstep + 1'b1;
          unique case (mstep)
            2'd0: begin
              p1 <= prod; sa <= bn;
              sb <= ad;
            end
            2'd1: begin
              p2 <= prod; sa <= ad;
              sb <= (k == KIND_W'(OP_DIV)) ? bn : bd;
            end
            default: begin
              p3 <= prod;
              state <= S_SUM;
            end
          endcase
        end
        S_SUM: begin
          state <= S_OUT;
          unique case (k)
            KIND_W'(OP_ADD), KIND_W'(OP_SUB): begin
              if (pn == qneg) begin
                neg_n <= pn; nmag <= pm + qm;
              end else if (pm >= qm) begin
                neg_n <= pn; nmag <= pm - qm;
              end else begin
                neg_n <= qneg; nmag <= qm - pm;
              end
              neg_d <= p3 < 0; dmag <= mag(p3);
              state <= S_GCD;
            end
            KIND_W'(OP_MUL): begin
              neg_n <= p1 < 0; nmag <= pm; neg_d <= p3 < 0; dmag <= mag(p3);
              state <= S_GCD;
            end
            KIND_W'(OP_DIV): begin
              neg_n <= p1 < 0; nmag <= pm; neg_d <= p3 < 0; dmag <= mag(p3);
              state <= S_GCD;
            end
            KIND_W'(OP_REDUCE), KIND_W'(OP_IS_RED): begin
              neg_n <= an < 0; nmag <= mag(PW'(an));
              neg_d <= ad < 0; dmag <= mag(PW'(ad));
              state <= S_GCD;
            end
            KIND_W'(OP_COMMON): begin
              res_num    <= NUM_W'(p1);
              second_num <= NUM_W'(p2);
              res_den    <= DEN_W'(p3);
              second_den <= DEN_W'(p3);
            end
            KIND_W'(OP_SIGN): begin
              if (an != 0) verdict <= ((an < 0) == (ad < 0)) ? 2'sd1 : -2'sd1;
            end
            default: begin
              // compare: sign of (an*bd - bn*ad) times sign of ad*bd
              if (p1 == p2) verdict <= 2'sd0;
              else verdict <= (((p1 > p2) ? 1'b1 : 1'b0) ^ (p3 < 0)) ?
                              2'sd1 : -2'sd1;
            end
          endcase
          gb <= '0;
          mstep <= '0;
        end
        // gcd by repeated remainder on the shared divider
        S_GCD: begin
          if (mstep == 2'd0) begin
            gb <= dmag; mstep <= 2'd1;
            dnd <= FW'(nmag); dvs <= FW'(dmag); dgo <= 1'b1;
          end else if (ddone) begin
            if (dr == '0) begin
              // gcd is the last divisor, now in gb
              if (k == KIND_W'(OP_IS_RED)) begin
                verdict <= (gb == MW'(1)) ? 2'sd1 : 2'sd0;
                state <= S_OUT;
              end else begin
                dnd <= FW'(nmag); dvs <= FW'(gb); dgo <= 1'b1;
                state <= S_DIVN;
              end
            end else begin
              gb <= MW'(dr);
              dnd <= FW'(gb); dvs <= dr; dgo <= 1'b1;
            end
          end
        end
        S_DIVN: begin
          if (ddone) begin
            qn <= dq;
            dnd <= FW'(dmag); dvs <= FW'(gb); dgo <= 1'b1;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (ddone) begin
            res_num <= ((neg_n != neg_d) && qn != '0) ? NUM_W'(-qn) : NUM_W'(qn);
            res_den <= DEN_W'(dq);
            state <= S_OUT;
          end
        end
        default: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

>>> test/tb_rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives fraction commands into the rational arithmetic unit with random
// gaps, predicts every result in the bench and checks each result beat
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic signed [NUM_W-1:0] num2;
    logic signed [DEN_W-1:0] den2;
    logic signed [1:0]       verdict;
    logic                    error;
  } frac_result_t;

  class frac_scoreboard;
    frac_result_t pending[$];
    int mismatches;

    static function longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    static function longint unsigned mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // reduce sign-magnitude fraction, sign goes to the numerator
    static function void lowest_terms(bit nneg, longint unsigned nm, bit dneg,
                                      longint unsigned dm, ref frac_result_t r);
      longint unsigned g, n, d;
      g = gcd_of(nm, dm);
      n = nm / g;
      d = dm / g;
      r.num = NUM_W'(((nneg != dneg) && n != 0) ? -n : n);
      r.den = DEN_W'(d);
    endfunction

    function void note_command(logic [3:0] k, logic signed [15:0] an_in,
                               logic signed [15:0] ad_in, logic signed [15:0] bn_in,
                               logic signed [15:0] bd_in);
      frac_result_t r;
      longint an, ad, bn, bd, p, q, d, l, rr;
      longint unsigned pm, qm, sm;
      bit pn, qn, sn, only_a;
      an = an_in; ad = ad_in; bn = bn_in; bd = bd_in;
      r = '{default: 0};
      only_a = (k == OP_REDUCE || k == OP_IS_RED || k == OP_SIGN);
      if (k > OP_CMP || ad == 0 || (!only_a && bd == 0) || (k == OP_DIV && bn == 0)) begin
        r.error = 1;
      end else begin
        case (op_t'(k))
          OP_ADD, OP_SUB: begin
            p = an * bd;
            q = bn * ad;
            pn = p < 0;
            qn = (q < 0) != (k == OP_SUB);
            pm = mag(p);
            qm = mag(q);
            if (pn == qn) begin
              sn = pn; sm = pm + qm;
            end else if (pm >= qm) begin
              sn = pn; sm = pm - qm;
            end else begin
              sn = qn; sm = qm - pm;
            end
            d = ad * bd;
            lowest_terms(sn, sm, d < 0, mag(d), r);
          end
          OP_MUL: begin
            p = an * bn; d = ad * bd;
            lowest_terms(p < 0, mag(p), d < 0, mag(d), r);
          end
          OP_DIV: begin
            p = an * bd; d = ad * bn;
            lowest_terms(p < 0, mag(p), d < 0, mag(d), r);
          end
          OP_REDUCE: lowest_terms(an < 0, mag(an), ad < 0, mag(ad), r);
          OP_IS_RED: r.verdict = (gcd_of(mag(an), mag(ad)) == 1) ? 2'sd1 : 2'sd0;
          OP_COMMON: begin
            d = ad * bd;
            r.num = NUM_W'(an * bd);
            r.den = DEN_W'(d);
            r.num2 = NUM_W'(bn * ad);
            r.den2 = DEN_W'(d);
          end
          OP_SIGN: if (an != 0) r.verdict = ((an < 0) == (ad < 0)) ? 2'sd1 : -2'sd1;
          default: begin
            if (ad < 0) begin an = -an; ad = -ad; end
            if (bd < 0) begin bn = -bn; bd = -bd; end
            l = an * bd;
            rr = bn * ad;
            r.verdict = (l > rr) ? 2'sd1 : (l < rr) ? -2'sd1 : 2'sd0;
          end
        endcase
      end
      pending.push_back(r);
    endfunction

    function void check_result(frac_result_t got);
      frac_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing pending");
        return;
      end
      exp_r = pending.pop_front();
      if (got.num !== exp_r.num || got.den !== exp_r.den || got.num2 !== exp_r.num2 ||
          got.den2 !== exp_r.den2 || got.verdict !== exp_r.verdict ||
          got.error !== exp_r.error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d/%0d %0d/%0d v%0d e%0d got %0d/%0d %0d/%0d v%0d e%0d",
                   exp_r.num, exp_r.den, exp_r.num2, exp_r.den2, exp_r.verdict,
                   exp_r.error, got.num, got.den, got.num2, got.den2, got.verdict,
                   got.error);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic [KIND_W-1:0] kind = 0;
  logic signed [15:0] num_a = 0, den_a = 0, num_b = 0, den_b = 0;
  logic busy, done, error;
  logic signed [NUM_W-1:0] res_num, second_num;
  logic signed [DEN_W-1:0] res_den, second_den;
  logic signed [1:0] verdict;

  frac_scoreboard board = new();
  int idle_cycles = 0;

  rational_arithmetic_unit uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done)
      board.check_result('{res_num, res_den, second_num, second_den, verdict, error});
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_rational_arithmetic_unit: errors");
      $finish;
    end
  end

  // start stays high after an accepted beat until the next gap begins
  task automatic issue(logic [3:0] k, logic signed [15:0] an, logic signed [15:0] ad,
                       logic signed [15:0] bn, logic signed [15:0] bd);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    kind <= k; num_a <= an; den_a <= ad; num_b <= bn; den_b <= bd;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(k, an, ad, bn, bd);
  endtask

  // mostly small operands so the gcd stays interesting, sometimes full range
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 4) == 0 ? 16'sh8000 : 16'sh7fff;
      2: return 0;
      default: return $signed(16'($urandom_range(0, 120))) - 16'sd60;
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    issue(OP_ADD, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    issue(OP_SUB, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
    issue(OP_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, -16'sd1);
    issue(OP_DIV, 16'sh8000, 16'sd1, 16'sh8000, -16'sd1);
    issue(OP_DIV, 3, 4, 0, 5);
    issue(OP_ADD, 1, 0, 1, 2);
    issue(OP_MUL, 1, 2, 1, 0);
    issue(OP_ADD, 0, 7, 0, -3);
    issue(OP_REDUCE, -6, -4, 0, 0);
    issue(OP_REDUCE, 0, -5, 1, 1);
    issue(OP_IS_RED, 0, 1, 0, 0);
    issue(OP_IS_RED, 0, -1, 0, 0);
    issue(OP_IS_RED, 0, 5, 0, 0);
    issue(OP_IS_RED, 4, 6, 0, 0);
    issue(OP_COMMON, -3, 4, 5, -6);
    issue(OP_COMMON, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
    issue(OP_SIGN, -3, -4, 0, 0);
    issue(OP_SIGN, 3, -4, 0, 0);
    issue(OP_SIGN, 0, 7, 0, 0);
    issue(OP_CMP, 1, -2, -1, 2);
    issue(OP_CMP, 1, -2, 1, 3);
    issue(OP_CMP, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    issue(OP_REDUCE, 3, 0, 0, 0);
    for (int k = 9; k < 16; k++) issue(4'(k), 1, 1, 1, 1);
    for (int i = 0; i < 1650; i++) begin
      if (i == 800) begin
        start <= 0;
        wait (board.pending.size() == 0);
        @(posedge clk);
      end
      issue(4'($urandom_range(0, 19) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 8)),
            pick_value(), pick_value(), pick_value(), pick_value());
    end
    start <= 0;
    wait (board.pending.size() == 0);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) $display("tb_rational_arithmetic_unit: clean");
    else $display("tb_rational_arithmetic_unit: errors");
    $finish;
  end
endmodule

>>> filelist.f
hdl/rau_pkg.sv
hdl/rau_divider.sv
hdl/rational_arithmetic_unit.sv
test/tb_rational_arithmetic_unit.sv
